FILE: hw/rtl/arll_pkg.sv
// Shared types and codes for the array-backed linked list engine.
// Holds the action and status codes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package arll_pkg;

    localparam int VALUE_W = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int IN_W = 40;
    localparam int OUT_W = 40;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND   = 2'd0,
        ACT_PREPEND  = 2'd1,
        ACT_READ_OUT = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // register the incoming item
        logic push;       // perform a push and load its result
        logic empty_rsp;  // load the empty-list result
        logic rd_first;   // read the head slot
        logic rd_next;    // read the slot linked from the current one
        logic emit_elem;  // load the element that was just read
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t action;
        logic    list_valid;
        logic    out_free;
        logic    at_end;
    } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/array_linked_list_engine.sv
// Array-backed singly linked list engine: appends, prepends and ordered read-out.
// A push or empty read loads its result in S_DECODE once the output register is free, then goes
// back to S_IDLE; an unused code goes back to S_IDLE with no result loaded.
// A read-out emits one element per cycle along the node RAM read port while the output is free.
// Output stalls hold the engine; a new item is taken once the previous one has finished.
// Reset (asynchronous, active low) empties the list and the fill count; node RAMs are not cleared.
// Depends on arll_pkg, arll_ctrl, arll_datapath and arll_ram.
`default_nettype none

module array_linked_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // s_tdata, from bit 0: action[1:0], item_value[33:2], zero fill to 40 bits.
    input  wire logic [arll_pkg::IN_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // m_tdata, from bit 0: status[1:0], out_value[33:2], zero fill to 40 bits.
    output logic [arll_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tlast
);

    arll_pkg::cmd_t  cmd;
    arll_pkg::stat_t stat;

    arll_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    arll_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/arll_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module arll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/arll_ctrl.sv
// Controller state machine of the linked list engine.
// Depends on arll_pkg; drives datapath commands from its status.
`default_nettype none

module arll_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire arll_pkg::stat_t stat,
    output arll_pkg::cmd_t       cmd
);

    arll_pkg::state_t state_reg;
    arll_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arll_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arll_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = arll_pkg::S_DECODE;
                end
            end
            arll_pkg::S_DECODE:
            begin
                case (stat.action)
                    arll_pkg::ACT_APPEND, arll_pkg::ACT_PREPEND:
                    begin
                        if (stat.out_free)
                        begin
                            state_next = arll_pkg::S_IDLE;
                        end
                    end
                    arll_pkg::ACT_READ_OUT:
                    begin
                        if (stat.list_valid)
                        begin
                            state_next = arll_pkg::S_EMIT;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = arll_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = arll_pkg::S_IDLE;
                    end
                endcase
            end
            arll_pkg::S_EMIT:
            begin
                if (stat.out_free && stat.at_end)
                begin
                    state_next = arll_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = arll_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            arll_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.capture = s_tvalid;
            end
            arll_pkg::S_DECODE:
            begin
                case (stat.action)
                    arll_pkg::ACT_APPEND, arll_pkg::ACT_PREPEND:
                    begin
                        cmd.push = stat.out_free;
                    end
                    arll_pkg::ACT_READ_OUT:
                    begin
                        cmd.rd_first = stat.list_valid;
                        cmd.empty_rsp = !stat.list_valid && stat.out_free;
                    end
                    default:
                    begin
                        cmd = '0;
                    end
                endcase
            end
            arll_pkg::S_EMIT:
            begin
                // The next read is issued in the same cycle the current element is loaded.
                cmd.emit_elem = stat.out_free;
                cmd.rd_next = stat.out_free && !stat.at_end;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Only one kind of result may be loaded into the output register per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.push, cmd.empty_rsp, cmd.emit_elem}) <= 1)
        else $error("more than one result loaded in a cycle");

    // No result is loaded while the output register still holds an untaken one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.empty_rsp || cmd.emit_elem) |-> stat.out_free)
        else $error("result loaded over a pending transaction");

    // A walk always starts from the decode state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == arll_pkg::S_EMIT) |-> $past(cmd.rd_first))
        else $error("walk entered without a head read");

endmodule

`default_nettype wire

FILE: hw/rtl/arll_datapath.sv
// Datapath of the linked list engine: node RAMs, head/tail/fill registers, output register.
// Depends on arll_pkg and arll_ram.
`default_nettype none

module arll_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire arll_pkg::cmd_t            cmd,
    output arll_pkg::stat_t                stat,
    input  wire logic [arll_pkg::IN_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [arll_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tlast
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VW = arll_pkg::VALUE_W;
    localparam int SW = arll_pkg::STATUS_W;
    localparam int PAD_W = arll_pkg::OUT_W - VW - SW;

    arll_pkg::action_t action_reg;
    logic [VW-1:0]     value_reg;

    logic [CNT_W-1:0]  fill_reg;
    logic              list_valid_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  cur_reg;

    logic              out_valid_reg;
    arll_pkg::status_t out_status_reg;
    logic [VW-1:0]     out_value_reg;
    logic              out_last_reg;

    logic              full;
    logic              push_ok;
    logic              is_back;
    logic [IDX_W-1:0]  slot;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;
    logic [IDX_W-1:0]  link_wdata;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [VW-1:0]     value_rdata;
    logic [IDX_W-1:0]  link_rdata;
    logic              out_free;
    logic              at_end;

    // Slots are never freed, so the lowest free slot is the fill count.
    assign full = (fill_reg == CNT_W'(CAPACITY));
    assign slot = fill_reg[IDX_W-1:0];
    assign push_ok = cmd.push && !full;
    assign is_back = (action_reg == arll_pkg::ACT_APPEND);

    assign link_we = push_ok && list_valid_reg;
    assign link_waddr = is_back ? tail_reg : slot;
    assign link_wdata = is_back ? slot : head_reg;

    assign rd_en = cmd.rd_first || cmd.rd_next;
    assign rd_addr = cmd.rd_first ? head_reg : link_rdata;

    assign out_free = !out_valid_reg || m_tready;
    assign at_end = (cur_reg == tail_reg);

    always_comb
    begin
        stat.action = action_reg;
        stat.list_valid = list_valid_reg;
        stat.out_free = out_free;
        stat.at_end = at_end;
    end

    arll_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY),
        .ADDR_W(IDX_W)
    ) u_value_ram (
        .clk    (clk),
        .wr_en  (push_ok),
        .wr_addr(slot),
        .wr_data(value_reg),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(value_rdata)
    );

    arll_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY),
        .ADDR_W(IDX_W)
    ) u_link_ram (
        .clk    (clk),
        .wr_en  (link_we),
        .wr_addr(link_waddr),
        .wr_data(link_wdata),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(link_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= arll_pkg::action_t'(s_tdata[arll_pkg::ACTION_W-1:0]);
            value_reg <= s_tdata[arll_pkg::ACTION_W +: VW];
        end
        if (rd_en)
        begin
            cur_reg <= rd_addr;
        end
        if (cmd.push)
        begin
            out_status_reg <= full ? arll_pkg::ST_FULL : arll_pkg::ST_OK;
            out_value_reg <= '0;
            out_last_reg <= 1'b1;
        end
        else if (cmd.empty_rsp)
        begin
            out_status_reg <= arll_pkg::ST_EMPTY;
            out_value_reg <= '0;
            out_last_reg <= 1'b1;
        end
        else if (cmd.emit_elem)
        begin
            out_status_reg <= arll_pkg::ST_OK;
            out_value_reg <= value_rdata;
            out_last_reg <= at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            list_valid_reg <= 1'b0;
            head_reg <= '0;
            tail_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (push_ok)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
                if (!list_valid_reg)
                begin
                    head_reg <= slot;
                    tail_reg <= slot;
                    list_valid_reg <= 1'b1;
                end
                else if (is_back)
                begin
                    tail_reg <= slot;
                end
                else
                begin
                    head_reg <= slot;
                end
            end
            if (cmd.push || cmd.empty_rsp || cmd.emit_elem)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{PAD_W{1'b0}}, out_value_reg, out_status_reg};
    assign m_tlast = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        list_valid_reg == (fill_reg != '0))
        else $error("list valid flag disagrees with fill count");

    // Head and tail always point at slots that have been written.
    assert property (@(posedge clk) disable iff (!rst_n)
        list_valid_reg |-> (CNT_W'(head_reg) < fill_reg) && (CNT_W'(tail_reg) < fill_reg))
        else $error("head or tail points at an unwritten slot");

    // A rejected push leaves the list untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && full) |=> $stable(fill_reg) && $stable(head_reg) && $stable(tail_reg))
        else $error("rejected push changed the list");

endmodule

`default_nettype wire
